>>> design/assert_macros.svh
// Assertion macros used by the RTL top level of the format specification parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: %m");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition: %m");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> design/fsp_pkg.sv
// Package: constants, types and helper functions of the format specification parser.
`timescale 1ns / 1ps
package fsp_pkg;

	// Width and precision counters saturate at 2^COUNT_BITS - 1
	localparam int COUNT_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int SUM_BITS   = COUNT_BITS + 4;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Length modifier codes
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_HH   = 3'd1;
	localparam logic [2:0] LEN_H    = 3'd2;
	localparam logic [2:0] LEN_LL   = 3'd3;
	localparam logic [2:0] LEN_L    = 3'd4;
	localparam logic [2:0] LEN_J    = 3'd5;
	localparam logic [2:0] LEN_Z    = 3'd6;

	// Characters of the grammar
	localparam logic [7:0] CH_BELOW_DIGIT = 8'd47;
	localparam logic [7:0] CH_ABOVE_DIGIT = 8'd58;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_H       = 8'h68;
	localparam logic [7:0] CH_L       = 8'h6C;
	localparam logic [7:0] CH_J       = 8'h6A;
	localparam logic [7:0] CH_Z       = 8'h7A;

	// One parsed specification
	typedef struct packed {
		logic                  flag_space;
		logic                  flag_hash;
		logic                  flag_zero;
		logic                  flag_plus;
		logic                  flag_minus;
		logic [FIELD_BITS-1:0] field_width;
		logic [FIELD_BITS-1:0] prec_value;
		logic                  prec_given;
		logic [2:0]            length_code;
		logic [7:0]            conv_char;
		logic                  conv_valid;
	} spec_t;

	// acc * 10 + digit, clamped to the counter maximum
	function automatic logic [COUNT_BITS-1:0] sat_digit(input logic [COUNT_BITS-1:0] acc,
			input logic [3:0] dig);
		logic [SUM_BITS-1:0] wide;
		wide = (SUM_BITS'(acc) << 3) + (SUM_BITS'(acc) << 1) + SUM_BITS'(dig);
		sat_digit = (wide > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : wide[COUNT_BITS-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c > CH_BELOW_DIGIT) && (c < CH_ABOVE_DIGIT);
	endfunction

	// Accepted conversion characters: s S p d i D o O u U x X c C %
	function automatic logic conv_ok(input logic [7:0] c);
		unique case (c)
			8'h73, 8'h53, 8'h70, 8'h64, 8'h69, 8'h44, 8'h6F, 8'h4F,
			8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43, CH_PERCENT: conv_ok = 1'b1;
			default: conv_ok = 1'b0;
		endcase
	endfunction

endpackage

>>> design/fsp_channels.sv
// Interfaces: character input channel and parsed specification output channel.
`timescale 1ns / 1ps
interface fsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, ch, start_req, input ready);
	modport sink (input valid, ch, start_req, output ready);
endinterface

interface fsp_spec_if import fsp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  flag_space;
	logic                  flag_hash;
	logic                  flag_zero;
	logic                  flag_plus;
	logic                  flag_minus;
	logic [FIELD_BITS-1:0] field_width;
	logic [FIELD_BITS-1:0] prec_value;
	logic                  prec_given;
	logic [2:0]            length_code;
	logic [7:0]            conv_char;
	logic                  conv_valid;

	modport source (output valid, flag_space, flag_hash, flag_zero, flag_plus, flag_minus,
		field_width, prec_value, prec_given, length_code, conv_char, conv_valid,
		input ready);
	modport sink (input valid, flag_space, flag_hash, flag_zero, flag_plus, flag_minus,
		field_width, prec_value, prec_given, length_code, conv_char, conv_valid,
		output ready);
endinterface

>>> design/format_spec_parser_unit.sv
// Top level: streaming printf conversion specification parser.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Feed the characters that follow a percent sign, one item each, with start_req set on
// the first. The unit takes one character per cycle while the skid entry of the output
// buffer is empty: a character is captured in an input register, then one decode step
// updates the parse state and, at the conversion character, loads one specification
// into a two-entry output buffer. The result passes through the input register and the
// output buffer. The rate is set by the parse state update in the decode stage.
// Characters that arrive outside a specification (no start_req) are consumed and
// produce nothing. Width and precision saturate at 2^COUNT_BITS - 1.
module format_spec_parser_unit import fsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fsp_char_if.sink  chars,
	fsp_spec_if.source specs
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FLAGS,
		PH_WIDTH,
		PH_PREC,
		PH_AFTERH,
		PH_AFTERL,
		PH_CONV
	} phase_t;

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       start_s1;

	// Parse state
	phase_t                phase_q;
	logic [4:0]            flags_q;
	logic [COUNT_BITS-1:0] width_q;
	logic [COUNT_BITS-1:0] prec_q;
	logic                  dot_q;
	logic                  frozen_q;
	logic [2:0]            len_q;

	// Output buffer: main register plus skid entry
	logic  out_valid_q;
	spec_t out_q;
	logic  skid_valid_q;
	spec_t skid_q;

	// Decode stage signals
	logic                  consume;
	phase_t                ph_e, ph_n;
	logic [4:0]            flags_e, flags_n;
	logic [COUNT_BITS-1:0] width_e, width_n;
	logic [COUNT_BITS-1:0] prec_e, prec_n;
	logic                  dot_e, dot_n;
	logic                  frozen_e, frozen_n;
	logic [2:0]            len_e, len_n;
	logic                  mod_pos;
	logic                  emit;
	logic                  dig;
	spec_t                 res;

	assign consume     = valid_s1 && !skid_valid_q;
	assign chars.ready = !valid_s1 || consume;
	assign dig         = is_digit(ch_s1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1    <= chars.ch;
			start_s1 <= chars.start_req;
		end
	end

	// Effective state: a start discards any unfinished specification
	always_comb begin
		if (start_s1) begin
			ph_e     = PH_FLAGS;
			flags_e  = '0;
			width_e  = '0;
			prec_e   = '0;
			dot_e    = 1'b0;
			frozen_e = 1'b0;
			len_e    = LEN_NONE;
		end else begin
			ph_e     = phase_q;
			flags_e  = flags_q;
			width_e  = width_q;
			prec_e   = prec_q;
			dot_e    = dot_q;
			frozen_e = frozen_q;
			len_e    = len_q;
		end
	end

	// Per-character decode
	always_comb begin
		ph_n     = ph_e;
		flags_n  = flags_e;
		width_n  = width_e;
		prec_n   = prec_e;
		dot_n    = dot_e;
		frozen_n = frozen_e;
		len_n    = len_e;
		mod_pos  = 1'b0;
		emit     = 1'b0;

		unique case (ph_e)
			PH_FLAGS: begin
				priority if (ch_s1 == CH_SPACE) begin
					flags_n[0] = 1'b1;
				end else if (ch_s1 == CH_HASH) begin
					flags_n[1] = 1'b1;
				end else if (ch_s1 == CH_ZERO) begin
					flags_n[2] = 1'b1;
				end else if (ch_s1 == CH_PLUS) begin
					flags_n[3] = 1'b1;
				end else if (ch_s1 == CH_MINUS) begin
					flags_n[4] = 1'b1;
				end else if (dig) begin
					width_n = sat_digit('0, ch_s1[3:0]);
					ph_n    = PH_WIDTH;
				end else if (ch_s1 == CH_DOT) begin
					dot_n = 1'b1;
					ph_n  = PH_PREC;
				end else begin
					mod_pos = 1'b1;
				end
			end
			PH_WIDTH: begin
				priority if (dig) begin
					width_n = sat_digit(width_e, ch_s1[3:0]);
				end else if (ch_s1 == CH_DOT) begin
					dot_n = 1'b1;
					ph_n  = PH_PREC;
				end else begin
					mod_pos = 1'b1;
				end
			end
			PH_PREC: begin
				// digits after a second dot are skipped
				priority if (ch_s1 == CH_DOT) begin
					frozen_n = 1'b1;
				end else if (dig) begin
					if (!frozen_e) begin
						prec_n = sat_digit(prec_e, ch_s1[3:0]);
					end
				end else begin
					mod_pos = 1'b1;
				end
			end
			PH_AFTERH: begin
				if (ch_s1 == CH_H) begin
					len_n = LEN_HH;
					ph_n  = PH_CONV;
				end else begin
					len_n = LEN_H;
					emit  = 1'b1;
				end
			end
			PH_AFTERL: begin
				if (ch_s1 == CH_L) begin
					len_n = LEN_LL;
					ph_n  = PH_CONV;
				end else begin
					len_n = LEN_L;
					emit  = 1'b1;
				end
			end
			PH_CONV: begin
				emit = 1'b1;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		// Modifier position: start a length modifier or take the conversion
		if (mod_pos) begin
			priority if (ch_s1 == CH_H) begin
				ph_n = PH_AFTERH;
			end else if (ch_s1 == CH_L) begin
				ph_n = PH_AFTERL;
			end else if (ch_s1 == CH_J) begin
				len_n = LEN_J;
				ph_n  = PH_CONV;
			end else if (ch_s1 == CH_Z) begin
				len_n = LEN_Z;
				ph_n  = PH_CONV;
			end else begin
				len_n = LEN_NONE;
				emit  = 1'b1;
			end
		end

		if (emit) begin
			ph_n = PH_IDLE;
		end
	end

	// Result assembled from the updated state
	always_comb begin
		res.flag_space  = flags_n[0];
		res.flag_hash   = flags_n[1];
		res.flag_zero   = flags_n[2];
		res.flag_plus   = flags_n[3];
		res.flag_minus  = flags_n[4];
		res.field_width = FIELD_BITS'(width_n);
		res.prec_value  = FIELD_BITS'(prec_n);
		res.prec_given  = dot_n;
		res.length_code = len_n;
		res.conv_char   = ch_s1;
		res.conv_valid  = conv_ok(ch_s1);
	end

	// Parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			flags_q  <= '0;
			width_q  <= '0;
			prec_q   <= '0;
			dot_q    <= 1'b0;
			frozen_q <= 1'b0;
			len_q    <= LEN_NONE;
		end else if (consume) begin
			phase_q  <= ph_n;
			flags_q  <= flags_n;
			width_q  <= width_n;
			prec_q   <= prec_n;
			dot_q    <= dot_n;
			frozen_q <= frozen_n;
			len_q    <= len_n;
		end
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (specs.ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (consume && emit && out_valid_q && !specs.ready) begin
				skid_valid_q <= 1'b1;
			end
			if (!out_valid_q || specs.ready) begin
				out_valid_q <= skid_valid_q || (consume && emit);
			end
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (!out_valid_q || specs.ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (!skid_valid_q) begin
			skid_q <= res;
		end
	end

	assign specs.valid       = out_valid_q;
	assign specs.flag_space  = out_q.flag_space;
	assign specs.flag_hash   = out_q.flag_hash;
	assign specs.flag_zero   = out_q.flag_zero;
	assign specs.flag_plus   = out_q.flag_plus;
	assign specs.flag_minus  = out_q.flag_minus;
	assign specs.field_width = out_q.field_width;
	assign specs.prec_value  = out_q.prec_value;
	assign specs.prec_given  = out_q.prec_given;
	assign specs.length_code = out_q.length_code;
	assign specs.conv_char   = out_q.conv_char;
	assign specs.conv_valid  = out_q.conv_valid;

	// Checks
	`ASSERT_ALWAYS(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`ASSERT_ALWAYS(a_stall_to_skid, clk, arst_n,
		(consume && emit && out_valid_q && !specs.ready) |=> skid_valid_q)
	`ASSERT_ALWAYS(a_idle_after_emit, clk, arst_n, (consume && emit) |=> phase_q == PH_IDLE)
	`ASSERT_ALWAYS(a_frozen_needs_dot, clk, arst_n, frozen_q |-> dot_q)
	`ASSERT_NEVER(a_len_code_range, clk, arst_n, len_q > LEN_Z)

endmodule
